// ===== design/llmc_pkg.sv =====
// llmc_pkg: shared types, codes, reset values and tables for the led light mode controller
`default_nettype none

package llmc_pkg;

  localparam int IDLE_COUNT_BITS_DEF = 16;

  // light modes
  localparam logic [2:0] MODE_OFF     = 3'd0;
  localparam logic [2:0] MODE_FULL    = 3'd1;
  localparam logic [2:0] MODE_QUARTER = 3'd2;
  localparam logic [2:0] MODE_DUAL    = 3'd3;
  localparam logic [2:0] MODE_STROBE  = 3'd4;
  localparam logic [2:0] MODE_SOS     = 3'd5;

  // main key events
  localparam logic [2:0] KEY_NONE   = 3'd0;
  localparam logic [2:0] KEY_SINGLE = 3'd1;
  localparam logic [2:0] KEY_DOUBLE = 3'd2;
  localparam logic [2:0] KEY_TRIPLE = 3'd3;
  localparam logic [2:0] KEY_LONG   = 3'd4;

  // momentary key events
  localparam logic [1:0] AUX_PRESS   = 2'd1;
  localparam logic [1:0] AUX_RELEASE = 2'd2;

  // action codes
  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  // battery tiers
  localparam logic [1:0] TIER_NORMAL = 2'd0;
  localparam logic [1:0] TIER_LOW    = 2'd1;
  localparam logic [1:0] TIER_CRIT   = 2'd2;

  // indicator codes
  localparam logic [3:0] IND_NONE      = 4'd0;
  localparam logic [3:0] IND_OFF       = 4'd1;
  localparam logic [3:0] IND_BATT_HIGH = 4'd2;
  localparam logic [3:0] IND_BATT_MED  = 4'd3;
  localparam logic [3:0] IND_BATT_LOW  = 4'd4;
  localparam logic [3:0] IND_BATT_CRIT = 4'd5;
  localparam logic [3:0] IND_STROBE    = 4'd6;
  localparam logic [3:0] IND_SOS       = 4'd7;
  localparam logic [3:0] IND_GREEN     = 4'd8;
  localparam logic [3:0] IND_RED       = 4'd9;

  // configuration register indexes
  localparam logic [2:0] CFG_STANDBY_TIMEOUT = 3'd0;
  localparam logic [2:0] CFG_CUTOFF_MV       = 3'd1;
  localparam logic [2:0] CFG_CRITICAL_MV     = 3'd2;
  localparam logic [2:0] CFG_LOW_MV          = 3'd3;
  localparam logic [2:0] CFG_HYSTERESIS_MV   = 3'd4;
  localparam logic [2:0] CFG_STROBE_HALF     = 3'd5;
  localparam logic [2:0] CFG_SAMPLE_PERIOD   = 3'd6;

  // configuration reset values
  localparam logic [13:0] STANDBY_TIMEOUT_RST = 14'd1000;
  localparam logic [12:0] CUTOFF_MV_RST       = 13'd2950;
  localparam logic [12:0] CRITICAL_MV_RST     = 13'd3100;
  localparam logic [12:0] LOW_MV_RST          = 13'd3400;
  localparam logic [8:0]  HYSTERESIS_MV_RST   = 9'd50;
  localparam logic [7:0]  STROBE_HALF_RST     = 8'd5;
  localparam logic [7:0]  SAMPLE_PERIOD_RST   = 8'd20;

  localparam logic [12:0] MV_BATT_HIGH   = 13'd3600;
  localparam logic [1:0]  CUTOFF_CONFIRM = 2'd2;

  // duties in thousandths
  localparam logic [9:0] DUTY_FULL      = 10'd1000;
  localparam logic [9:0] DUTY_QUARTER   = 10'd250;
  localparam logic [9:0] DUTY_FLASH_LOW = 10'd350;
  localparam logic [9:0] DUTY_CRIT      = 10'd50;

  localparam logic [4:0] SOS_LEN = 5'd18;

  typedef struct packed {
    logic        action;
    logic [2:0]  key_event;
    logic [1:0]  aux_event;
    logic [12:0] battery_mv;
    logic [2:0]  new_mode;
  } in_item_t;

  typedef struct packed {
    logic [9:0] main_duty;
    logic [9:0] aux_duty;
    logic [2:0] light_mode;
    logic [1:0] battery_tier;
    logic [3:0] indicator;
    logic       cutoff_request;
    logic       standby_request;
  } out_item_t;

  typedef struct packed {
    logic [2:0]  index;
    logic [13:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic [12:0] cutoff_mv;
    logic [12:0] critical_mv;
    logic [12:0] low_mv;
    logic [8:0]  hysteresis_mv;
  } batt_cfg_t;

  typedef struct packed {
    logic [1:0] cutoff_seen;
    logic [1:0] tier;
  } batt_state_t;

  typedef struct packed {
    batt_state_t st;
    logic [3:0]  ind;
    logic        cut;
  } batt_res_t;

  // morse element lengths in ticks: dots, dashes, gaps and the word pause
  function automatic logic [7:0] sos_len(input logic [4:0] idx);
    logic [7:0] len;
    unique case (idx)
      5'd5, 5'd6, 5'd8, 5'd10, 5'd11: len = 8'd60;
      5'd17:                          len = 8'd140;
      default:                        len = 8'd20;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== design/llmc_chan_if.sv =====
// llmc_chan_if: valid/ready channel carrying one payload item
`default_nettype none

interface llmc_chan_if #(
  parameter type item_t = logic
);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== design/llmc_batt.sv =====
// llmc_batt: one battery evaluation, cutoff confirm and tier hysteresis
`default_nettype none

module llmc_batt (
  input  logic                  en,
  input  logic [12:0]           mv,
  input  llmc_pkg::batt_cfg_t   cfg,
  input  llmc_pkg::batt_state_t st_in,
  output llmc_pkg::batt_res_t   res
);
  import llmc_pkg::*;

  logic [1:0]  cs_inc;
  logic [13:0] crit_up;
  logic [13:0] low_up;

  assign cs_inc  = (st_in.cutoff_seen < CUTOFF_CONFIRM) ? st_in.cutoff_seen + 2'd1
                                                        : st_in.cutoff_seen;
  assign crit_up = {1'b0, cfg.critical_mv} + {5'd0, cfg.hysteresis_mv};
  assign low_up  = {1'b0, cfg.low_mv} + {5'd0, cfg.hysteresis_mv};

  always_comb begin
    res.st  = st_in;
    res.ind = IND_NONE;
    res.cut = 1'b0;
    if (en) begin
      if (mv < cfg.cutoff_mv) begin
        res.st.cutoff_seen = cs_inc;
        if (cs_inc >= CUTOFF_CONFIRM) begin
          res.cut = 1'b1;
          res.ind = IND_RED;
        end
      end else begin
        res.st.cutoff_seen = 2'd0;
      end
      if (!res.cut) begin
        // falling is immediate, climbing needs the hysteresis margin
        if (mv < cfg.critical_mv) begin
          res.st.tier = TIER_CRIT;
        end else if (mv < cfg.low_mv) begin
          if (st_in.tier != TIER_CRIT || {1'b0, mv} >= crit_up) begin
            res.st.tier = TIER_LOW;
          end
        end else if ({1'b0, mv} >= low_up) begin
          res.st.tier = TIER_NORMAL;
        end
        if (mv >= MV_BATT_HIGH) begin
          res.ind = IND_BATT_HIGH;
        end else if (mv >= cfg.low_mv) begin
          res.ind = IND_BATT_MED;
        end else if (mv >= cfg.critical_mv) begin
          res.ind = IND_BATT_LOW;
        end else begin
          res.ind = IND_BATT_CRIT;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== design/led_light_mode_controller.sv =====
// led_light_mode_controller: top level, mode, battery, timer and idle logic per tick
//
//   channel   role    payload
//   tick      sink    in_item_t  (action, key_event, aux_event, battery_mv, new_mode)
//   result    source  out_item_t (duties, mode, tier, indicator, requests)
//   cfg       sink    cfg_item_t (register index, write data), always ready
//
// one item per cycle sustained while result is not stalled; each item is held in the input
// register and its result is loaded into the output register when that register is free.
// the step is one pass of compare-and-count logic with at most two chained battery
// evaluations between those registers.
// rst is synchronous and clears state, counters and configuration to defaults.
// a stalled result holds the output register; the input register keeps taking items
// while it is empty or the output register is empty or empties in the same cycle.
`default_nettype none

module led_light_mode_controller #(
  parameter int IDLE_COUNT_BITS = llmc_pkg::IDLE_COUNT_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  llmc_chan_if.sink   tick,
  llmc_chan_if.source result,
  llmc_chan_if.sink   cfg
);
  import llmc_pkg::*;

  // configuration
  logic [13:0] standby_timeout;
  batt_cfg_t   bcfg;
  logic [7:0]  strobe_half;
  logic [7:0]  sample_period;

  // pipeline
  logic      s1_valid;
  in_item_t  s1_item;
  logic      out_valid;
  out_item_t out_item;
  logic      out_free;
  logic      s1_adv;

  // state
  logic [2:0]                 mode, mode_next;
  batt_state_t                bst, bst_next;
  logic                       override_held, override_held_next;
  logic [7:0]                 strobe_count, strobe_count_next;
  logic                       strobe_on, strobe_on_next;
  logic [4:0]                 sos_index, sos_index_next;
  logic [7:0]                 sos_count, sos_count_next;
  logic [7:0]                 sample_count, sample_count_next;
  logic [IDLE_COUNT_BITS-1:0] idle_count, idle_count_next;

  logic      e1_en, e2_en;
  batt_res_t e1_res, e2_res;
  logic [3:0] ind_pre;
  logic       stby;
  out_item_t  out_next;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      standby_timeout    <= STANDBY_TIMEOUT_RST;
      bcfg.cutoff_mv     <= CUTOFF_MV_RST;
      bcfg.critical_mv   <= CRITICAL_MV_RST;
      bcfg.low_mv        <= LOW_MV_RST;
      bcfg.hysteresis_mv <= HYSTERESIS_MV_RST;
      strobe_half        <= STROBE_HALF_RST;
      sample_period      <= SAMPLE_PERIOD_RST;
    end else if (cfg.valid) begin
      unique case (cfg.data.index)
        CFG_STANDBY_TIMEOUT: standby_timeout    <= cfg.data.value;
        CFG_CUTOFF_MV:       bcfg.cutoff_mv     <= cfg.data.value[12:0];
        CFG_CRITICAL_MV:     bcfg.critical_mv   <= cfg.data.value[12:0];
        CFG_LOW_MV:          bcfg.low_mv        <= cfg.data.value[12:0];
        CFG_HYSTERESIS_MV:   bcfg.hysteresis_mv <= cfg.data.value[8:0];
        CFG_STROBE_HALF:     strobe_half        <= cfg.data.value[7:0];
        CFG_SAMPLE_PERIOD:   sample_period      <= cfg.data.value[7:0];
        default: ;
      endcase
    end
  end

  assign out_free     = !out_valid || result.ready;
  assign s1_adv       = s1_valid && out_free;
  assign tick.ready   = !s1_valid || out_free;
  assign result.valid = out_valid;
  assign result.data  = out_item;

  // first evaluation: set command to a lit mode, momentary release while lit, or single click from off
  always_comb begin
    if (s1_item.action == ACT_SET) begin
      e1_en = (s1_item.new_mode <= MODE_SOS) && (s1_item.new_mode != MODE_OFF);
    end else begin
      e1_en = (s1_item.aux_event == AUX_RELEASE && mode != MODE_OFF) ||
              (s1_item.key_event == KEY_SINGLE && mode == MODE_OFF);
    end
  end

  llmc_batt u_batt_event (
    .en    (e1_en),
    .mv    (s1_item.battery_mv),
    .cfg   (bcfg),
    .st_in (bst),
    .res   (e1_res)
  );

  llmc_batt u_batt_sample (
    .en    (e2_en),
    .mv    (s1_item.battery_mv),
    .cfg   (bcfg),
    .st_in (e1_res.st),
    .res   (e2_res)
  );

  always_comb begin
    mode_next          = mode;
    override_held_next = override_held;
    strobe_count_next  = strobe_count;
    strobe_on_next     = strobe_on;
    sos_index_next     = sos_index;
    sos_count_next     = sos_count;
    sample_count_next  = sample_count;
    idle_count_next    = idle_count;
    ind_pre            = IND_NONE;
    stby               = 1'b0;
    e2_en              = 1'b0;
    if (s1_item.action == ACT_SET) begin
      if (s1_item.new_mode <= MODE_SOS) begin
        mode_next       = s1_item.new_mode;
        idle_count_next = '0;
        ind_pre         = (s1_item.new_mode == MODE_OFF) ? IND_OFF : e1_res.ind;
      end
    end else begin
      if (s1_item.aux_event == AUX_PRESS) begin
        override_held_next = 1'b1;
        ind_pre            = IND_GREEN;
      end else if (s1_item.aux_event == AUX_RELEASE) begin
        override_held_next = 1'b0;
        ind_pre            = (mode == MODE_OFF) ? IND_OFF : e1_res.ind;
      end
      if (s1_item.key_event != KEY_NONE) begin
        idle_count_next = '0;
        unique case (s1_item.key_event)
          KEY_SINGLE: begin
            if (mode == MODE_OFF) begin
              mode_next = MODE_FULL;
              ind_pre   = e1_res.ind;
            end else if (mode == MODE_FULL) begin
              mode_next = MODE_QUARTER;
            end else if (mode == MODE_QUARTER) begin
              mode_next = MODE_DUAL;
            end else begin
              mode_next = MODE_OFF;
              ind_pre   = IND_OFF;
            end
          end
          KEY_DOUBLE: begin
            mode_next         = MODE_STROBE;
            strobe_count_next = 8'd0;
            strobe_on_next    = 1'b1;
            ind_pre           = IND_STROBE;
          end
          KEY_TRIPLE: begin
            mode_next      = MODE_SOS;
            sos_index_next = 5'd0;
            sos_count_next = 8'd0;
            ind_pre        = IND_SOS;
          end
          KEY_LONG: begin
            mode_next = MODE_OFF;
            ind_pre   = IND_OFF;
          end
          default: ;
        endcase
      end
      if (mode_next == MODE_STROBE) begin
        strobe_count_next = strobe_count_next + 8'd1;
        if (strobe_count_next >= strobe_half) begin
          strobe_count_next = 8'd0;
          strobe_on_next    = !strobe_on_next;
        end
      end else if (mode_next == MODE_SOS) begin
        if (sos_index_next >= SOS_LEN) begin
          sos_index_next = 5'd0;
        end
        sos_count_next = sos_count_next + 8'd1;
        if (sos_count_next >= sos_len(sos_index_next)) begin
          sos_count_next = 8'd0;
          sos_index_next = (sos_index_next == SOS_LEN - 5'd1) ? 5'd0 : sos_index_next + 5'd1;
        end
      end
      if (mode_next != MODE_OFF || override_held_next) begin
        sample_count_next = sample_count_next + 8'd1;
        if (sample_count_next >= sample_period) begin
          sample_count_next = 8'd0;
          e2_en             = 1'b1;
        end
      end
      if (mode_next == MODE_OFF && !override_held_next) begin
        if (idle_count_next != '1) begin
          idle_count_next = idle_count_next + IDLE_COUNT_BITS'(1);
        end
        if (idle_count_next >= IDLE_COUNT_BITS'(standby_timeout)) begin
          stby = 1'b1;
        end
      end
    end
  end

  assign bst_next = e2_res.st;

  // duties follow the state after the step
  always_comb begin
    logic [9:0] flash;
    flash                    = (bst_next.tier == TIER_LOW) ? DUTY_FLASH_LOW : DUTY_FULL;
    out_next.main_duty       = 10'd0;
    out_next.aux_duty        = 10'd0;
    out_next.light_mode      = mode_next;
    out_next.battery_tier    = bst_next.tier;
    out_next.indicator       = e2_en ? e2_res.ind : ind_pre;
    out_next.cutoff_request  = e1_res.cut || e2_res.cut;
    out_next.standby_request = stby;
    if (override_held_next) begin
      out_next.main_duty = (bst_next.tier == TIER_CRIT) ? DUTY_QUARTER : DUTY_FULL;
    end else if (mode_next == MODE_OFF) begin
      out_next.main_duty = 10'd0;
    end else if (bst_next.tier == TIER_CRIT) begin
      out_next.main_duty = DUTY_CRIT;
    end else begin
      unique case (mode_next)
        MODE_FULL:    out_next.main_duty = (bst_next.tier == TIER_LOW) ? DUTY_QUARTER : DUTY_FULL;
        MODE_QUARTER: out_next.main_duty = DUTY_QUARTER;
        MODE_DUAL: begin
          out_next.main_duty = (bst_next.tier == TIER_LOW) ? DUTY_QUARTER : DUTY_FULL;
          out_next.aux_duty  = DUTY_FULL;
        end
        MODE_STROBE:  out_next.main_duty = strobe_on_next ? flash : 10'd0;
        MODE_SOS: begin
          // even elements are lit, odd ones are gaps
          if (sos_index_next < SOS_LEN && !sos_index_next[0]) begin
            out_next.main_duty = flash;
          end
        end
        default: ;
      endcase
    end
    if (out_next.cutoff_request) begin
      out_next.main_duty = 10'd0;
      out_next.aux_duty  = 10'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      mode          <= MODE_OFF;
      bst           <= '0;
      override_held <= 1'b0;
      strobe_count  <= 8'd0;
      strobe_on     <= 1'b0;
      sos_index     <= 5'd0;
      sos_count     <= 8'd0;
      sample_count  <= 8'd0;
      idle_count    <= '0;
    end else begin
      if (tick.ready) begin
        s1_valid <= tick.valid;
      end
      if (out_free) begin
        out_valid <= s1_valid;
      end
      if (s1_adv) begin
        mode          <= mode_next;
        bst           <= bst_next;
        override_held <= override_held_next;
        strobe_count  <= strobe_count_next;
        strobe_on     <= strobe_on_next;
        sos_index     <= sos_index_next;
        sos_count     <= sos_count_next;
        sample_count  <= sample_count_next;
        idle_count    <= idle_count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_item <= tick.data;
    end
    if (s1_adv) begin
      out_item <= out_next;
    end
  end

endmodule

`default_nettype wire
